/* design/pgh_pkg.sv */
// ----------------------------------------------------------------------------
// pgh_pkg
// Shared types, constants and the add-rotate-xor round of the streaming
// 64-bit hash unit.
// ----------------------------------------------------------------------------
package pgh_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned SeedW     = 32;
  localparam int unsigned LenW      = 12;
  localparam int unsigned CountW    = 10;
  localparam int unsigned NumLanes  = 4;
  localparam int unsigned FinRounds = 6;

  localparam logic [LenW-1:0] LenReset = 12'd56;

  localparam int unsigned RotA = 14;
  localparam int unsigned RotB = 23;
  localparam int unsigned RotC = 16;
  localparam int unsigned RotD = 40;

  typedef logic [WordW-1:0]         word_t;
  typedef word_t [NumLanes-1:0]     quad_t;

  // Everything the final rounds need for one message
  typedef struct packed {
    quad_t              sums;
    quad_t              blk;
    logic [SeedW-1:0]   seed;
  } fin_t;

  function automatic word_t rotl(word_t x, int unsigned r);
    return (x << r) | (x >> (WordW - r));
  endfunction

  function automatic quad_t mix_round(quad_t s_in, quad_t b, word_t add);
    quad_t s;
    word_t old;
    s = s_in;

    old  = s[1];
    s[0] = s[0] + old + b[3];
    s[1] = s[0] + rotl(old, RotA) + add;

    old  = s[3];
    s[2] = s[2] + old + b[2];
    s[3] = s[2] + rotl(old, RotB);

    old  = s[3];
    s[0] = s[0] + old + b[1];
    s[3] = s[0] ^ rotl(old, RotC);

    old  = s[1];
    s[2] = s[2] + old + b[0];
    s[1] = s[2] ^ rotl(old, RotD);
    return s;
  endfunction

endpackage

/* design/pgh_in_if.sv */
// ----------------------------------------------------------------------------
// pgh_in_if
// Message word channel: valid/ready with one 64-bit word and the seed.
// ----------------------------------------------------------------------------
interface pgh_in_if;
  logic                    valid;
  logic                    ready;
  logic [pgh_pkg::WordW-1:0] data_word;
  logic [pgh_pkg::SeedW-1:0] seed;

  modport source (output valid, output data_word, output seed, input ready);
  modport sink   (input valid, input data_word, input seed, output ready);
endinterface

/* design/pgh_out_if.sv */
// ----------------------------------------------------------------------------
// pgh_out_if
// Hash result channel: valid/ready with one 64-bit hash.
// ----------------------------------------------------------------------------
interface pgh_out_if;
  logic                      valid;
  logic                      ready;
  logic [pgh_pkg::WordW-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

/* design/pgh_final_pipe.sv */
// ----------------------------------------------------------------------------
// pgh_final_pipe
// Six seeded rounds, one per stage, then the lane sum into the result
// register. All stages advance together when advance_i is high.
// ----------------------------------------------------------------------------
module pgh_final_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic                      valid_i,
  input  pgh_pkg::fin_t             fin_i,
  output logic                      valid_o,
  output logic [pgh_pkg::WordW-1:0] hash_o
);

  pgh_pkg::fin_t                    st_q [pgh_pkg::FinRounds+1];
  logic [pgh_pkg::FinRounds:0]      vld_q;
  logic                             out_vld_q;
  logic [pgh_pkg::WordW-1:0]        hash_q;
  logic [pgh_pkg::WordW-1:0]        sum_lo, sum_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (advance_i) begin
      vld_q     <= {vld_q[pgh_pkg::FinRounds-1:0], valid_i};
      out_vld_q <= vld_q[pgh_pkg::FinRounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      st_q[0] <= fin_i;
      for (int i = 1; i <= pgh_pkg::FinRounds; i++) begin
        st_q[i].sums <= pgh_pkg::mix_round(st_q[i-1].sums, st_q[i-1].blk,
                                           {{(pgh_pkg::WordW-pgh_pkg::SeedW){1'b0}},
                                            st_q[i-1].seed});
        st_q[i].blk  <= st_q[i-1].blk;
        st_q[i].seed <= st_q[i-1].seed;
      end
      hash_q <= sum_lo + sum_hi;
    end
  end

  assign sum_lo = st_q[pgh_pkg::FinRounds].sums[0] + st_q[pgh_pkg::FinRounds].sums[1];
  assign sum_hi = st_q[pgh_pkg::FinRounds].sums[2] + st_q[pgh_pkg::FinRounds].sums[3];

  assign valid_o = out_vld_q;
  assign hash_o  = hash_q;

endmodule

/* design/pengy_hash_64_unit.sv */
// ----------------------------------------------------------------------------
// pengy_hash_64_unit
// Streaming 64-bit hash of fixed-length messages fed as little-endian words.
//
//  channel   dir  handshake     payload
//  msg_i     in   valid/ready   data_word[63:0], seed[31:0]
//  hash_o    out  valid/ready   hash_value[63:0]
//  cfg       in   cfg_we_i      cfg_wdata_i[11:0] (message length in bytes)
//
// One word is taken per cycle while the pipeline advances; the block round
// runs in the same cycle as the word that completes a 32-byte block. The last
// word's state is registered, the six final rounds take one stage each and
// the lane sum is registered as the hash output.
// Reset clears the word count and pipeline valids; no clearing pass.
// A held result stalls the whole pipeline; msg_i.ready drops only then.
// ----------------------------------------------------------------------------
module pengy_hash_64_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pgh_pkg::LenW-1:0] cfg_wdata_i,
  pgh_in_if.sink                   msg_i,
  pgh_out_if.source                hash_o
);

  logic [pgh_pkg::LenW-1:0]   len_q;
  logic [pgh_pkg::CountW-1:0] wt_q, wt_d;
  pgh_pkg::quad_t             sums_q, sums_d, base_sums;
  pgh_pkg::quad_t             blk_q, blk_d, base_blk;
  pgh_pkg::fin_t              fin;

  logic                       advance, accept, start, last, full_blk;
  logic                       fin_vld;
  logic [pgh_pkg::CountW+2:0] off;
  logic [pgh_pkg::CountW+3:0] end_off;
  logic [pgh_pkg::CountW+2:0] valid_bytes;
  logic [3:0]                 nbytes;
  logic [pgh_pkg::WordW-1:0]  bmask;
  logic [1:0]                 slot;

  assign advance     = !fin_vld || hash_o.ready;
  assign accept      = msg_i.valid && advance;
  assign msg_i.ready = advance;

  always_comb begin
    start = (wt_q == '0);
    slot  = wt_q[1:0];
    off     = {wt_q, 3'b000};
    end_off = {1'b0, off} + 14'd8;

    if (start) begin
      base_sums    = '0;
      base_sums[3] = {{(pgh_pkg::WordW-pgh_pkg::LenW){1'b0}}, len_q};
      base_blk     = '0;
    end else begin
      base_sums = sums_q;
      base_blk  = blk_q;
    end

    // Count bytes of this word that lie inside the message
    valid_bytes = (off >= {1'b0, len_q}) ? '0 : ({1'b0, len_q} - off);
    nbytes      = (valid_bytes >= 13'd8) ? 4'd8 : {1'b0, valid_bytes[2:0]};
    for (int k = 0; k < 8; k++) begin
      bmask[k*8 +: 8] = (4'(k) < nbytes) ? 8'hFF : 8'h00;
    end

    blk_d       = base_blk;
    blk_d[slot] = (base_blk[slot] & ~bmask) | (msg_i.data_word & bmask);

    full_blk = (slot == 2'd3) && (end_off <= {2'b00, len_q});
    sums_d   = full_blk ? pgh_pkg::mix_round(base_sums, blk_d, '0) : base_sums;

    last = (end_off >= {2'b00, len_q});
    wt_d = last ? '0 : wt_q + 10'd1;

    fin.sums = sums_d;
    fin.blk  = blk_d;
    fin.seed = msg_i.seed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= pgh_pkg::LenReset;
      wt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (accept) begin
        wt_q <= wt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sums_q <= sums_d;
      blk_q  <= blk_d;
    end
  end

  pgh_final_pipe u_final (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (accept && last),
    .fin_i     (fin),
    .valid_o   (fin_vld),
    .hash_o    (hash_o.hash_value)
  );

  assign hash_o.valid = fin_vld;

  // A message never runs past 512 words
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wt_q[pgh_pkg::CountW-1])
    else $error("word count out of range");

  // Input stalls only behind a held result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !msg_i.ready |-> (hash_o.valid && !hash_o.ready))
    else $error("input stalled without a held result");

  // A message start loads the length into the fourth sum
  a_len_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && start && !last) |=>
      (sums_q[3] == {{(pgh_pkg::WordW-pgh_pkg::LenW){1'b0}}, $past(len_q)}))
    else $error("fourth sum not loaded with length");

  // The word that ends a message restarts the count
  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (wt_q == '0))
    else $error("word count not cleared at message end");

endmodule
